// ===== rtl/ncq_pkg.sv =====
// Shared types, constants and weight tables for the Newton-Cotes quadrature engine.
package ncq_pkg;

   localparam int MAX_SEGMENTS = 4096;
   localparam int SEG_W        = 13;
   localparam int X_W          = 24;
   localparam int AREA_W       = 64;
   localparam int RULE_W       = 3;

   localparam logic [RULE_W-1:0] RULE_LEFT    = 3'd0;
   localparam logic [RULE_W-1:0] RULE_MID     = 3'd1;
   localparam logic [RULE_W-1:0] RULE_RIGHT   = 3'd2;
   localparam logic [RULE_W-1:0] RULE_TRAP    = 3'd3;
   localparam logic [RULE_W-1:0] RULE_SIMPSON = 3'd4;
   localparam logic [RULE_W-1:0] RULE_S38     = 3'd5;
   localparam logic [RULE_W-1:0] RULE_BOOLE   = 3'd6;
   localparam logic [RULE_W-1:0] RULE_BAD     = 3'd7;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [19:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
      logic [19:0] remainder;
   } div_rsp_type;

   // weight of sample point j (twelfths 0,3,4,6,8,9,12) for a rule
   function automatic logic [3:0] ncq_wtab(input logic [RULE_W-1:0] r, input int j);
      logic [3:0] w;
      w = 4'd0;
      unique case (r)
         RULE_LEFT:    w = (j == 0) ? 4'd1 : 4'd0;
         RULE_MID:     w = (j == 3) ? 4'd1 : 4'd0;
         RULE_RIGHT:   w = (j == 6) ? 4'd1 : 4'd0;
         RULE_SIMPSON: w = (j == 0 || j == 6) ? 4'd1 : ((j == 3) ? 4'd4 : 4'd0);
         RULE_S38:     w = (j == 0 || j == 6) ? 4'd1 :
                           ((j == 2 || j == 4) ? 4'd3 : 4'd0);
         RULE_BOOLE:   w = (j == 0 || j == 6) ? 4'd7 :
                           ((j == 3) ? 4'd12 : 4'd0);
         default:      w = (j == 0 || j == 6) ? 4'd1 : 4'd0;
      endcase
      return w;
   endfunction

   // Boole weight 32 does not fit 4 bits: handled separately
   function automatic logic [5:0] ncq_weight(input logic [RULE_W-1:0] r,
                                             input logic [3:0] m,
                                             input logic first, input logic last);
      logic [5:0] w;
      w = 6'd0;
      unique case (m)
         4'd0: begin
            if (!last) w = w + {2'b0, ncq_wtab(r, 0)};
            if (!first) w = w + {2'b0, ncq_wtab(r, 6)};
         end
         4'd3:  w = (r == RULE_BOOLE) ? 6'd32 : {2'b0, ncq_wtab(r, 1)};
         4'd4:  w = {2'b0, ncq_wtab(r, 2)};
         4'd6:  w = {2'b0, ncq_wtab(r, 3)};
         4'd8:  w = {2'b0, ncq_wtab(r, 4)};
         4'd9:  w = (r == RULE_BOOLE) ? 6'd32 : {2'b0, ncq_wtab(r, 5)};
         default: w = 6'd0;
      endcase
      return w;
   endfunction

   function automatic logic [6:0] ncq_divisor(input logic [RULE_W-1:0] r);
      logic [6:0] d;
      unique case (r)
         RULE_LEFT, RULE_MID, RULE_RIGHT: d = 7'd1;
         RULE_SIMPSON: d = 7'd6;
         RULE_S38:     d = 7'd8;
         RULE_BOOLE:   d = 7'd90;
         default:      d = 7'd2;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/ncq_div.sv =====
// Radix-2 restoring divider, 64-bit dividend by 20-bit divisor, one bit per cycle.
module ncq_div (
   input  logic                clock,
   input  logic                reset,
   input  ncq_pkg::div_req_type req,
   output ncq_pkg::div_rsp_type rsp
);
   import ncq_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [19:0] rem_ff, rem_in;
   logic [19:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [20:0] trial;
   logic [20:0] diff;

   // one quotient bit per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]};
      diff    = trial - {1'b0, dsr_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[19:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[19:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== rtl/newton_cotes_quadrature_engine_unit.sv =====
// Newton-Cotes composite quadrature engine: sequencer, sample pipeline, shared multiplier.
// Steps from accept to result valid for N segments: the step division, 12*N+1 samples,
// the pipeline drain, the mean division, the final scaling and the output register;
// a stalled result holds the engine.
// One 32x32 multiplier and one 64-step bit-serial divider are shared. One item at a time;
// the next accept can come in the same cycle as the result. Zero segments: result via S_ZERO.
// Reset: synchronous, rule = trapezium.
module newton_cotes_quadrature_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [23:0] req_start_x,
   input  logic signed [23:0] req_end_x,
   input  logic [12:0] req_segment_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [63:0] rsp_area,
   output logic        rsp_error,
   output logic        rsp_saturated,
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata
);
   import ncq_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV1  = 4'd1;
   localparam logic [3:0] S_WAIT1 = 4'd2;
   localparam logic [3:0] S_RUN   = 4'd3;
   localparam logic [3:0] S_FLUSH = 4'd4;
   localparam logic [3:0] S_DIV2  = 4'd5;
   localparam logic [3:0] S_WAIT2 = 4'd6;
   localparam logic [3:0] S_MLO   = 4'd7;
   localparam logic [3:0] S_MHI   = 4'd8;
   localparam logic [3:0] S_SUM   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;
   localparam logic [3:0] S_ZERO  = 4'd11;

   logic [3:0]  state_ff, state_in;
   logic [2:0]  rule_ff;

   // job registers
   logic signed [32:0] base_ff;
   logic               neg_ff;
   logic [24:0]        dmag_ff;
   logic [12:0]        n_ff;
   logic [15:0]        den_ff;
   logic [2:0]         jrule_ff;

   // incremental quotient of (A*k + 6N) / 12N
   logic [32:0] qa_ff, q_ff, q_in;
   logic [15:0] ra_ff;
   logic [16:0] r_ff, r_in;
   logic [15:0] k_ff;
   logic [3:0]  m_ff;
   logic [2:0]  fl_ff;

   // sample pipeline
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [32:0] x1_ff, x2_ff, x3_ff;
   logic [31:0]        mag2_ff;
   logic [5:0]         w1_ff, w2_ff, w3_ff, w4_ff;
   logic [40:0]        f4_ff;
   logic [63:0]        acc_ff;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] p_ff;

   logic [63:0] fbar_ff;
   logic [63:0] lo_ff;
   logic [79:0] amag_ff;

   logic        rsp_valid_ff;
   logic [63:0] area_ff;
   logic        err_ff, sat_ff;

   div_req_type dreq;
   div_rsp_type drsp;

   logic        accept;
   logic        out_free;
   logic signed [25:0] dsig;
   logic [12:0] n_clip;
   logic [18:0] div2;
   logic signed [34:0] xsum;
   logic [38:0] sq;
   logic signed [43:0] fsum;
   logic [95:0] total;

   ncq_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !(rsp_valid_ff && rsp_stall);
   assign dsig     = 26'(req_end_x) - 26'(req_start_x);
   assign n_clip   = (req_segment_count > 13'(MAX_SEGMENTS)) ? 13'(MAX_SEGMENTS)
                                                              : req_segment_count;
   assign div2     = 19'(n_ff) * 19'(ncq_divisor(jrule_ff));

   // divider requests
   always_comb begin
      dreq.start    = 1'b0;
      dreq.dividend = '0;
      dreq.divisor  = '0;
      if (state_ff == S_DIV1) begin
         dreq.start    = 1'b1;
         dreq.dividend = {31'b0, dmag_ff, 8'b0};
         dreq.divisor  = {4'b0, den_ff};
      end else if (state_ff == S_DIV2) begin
         dreq.start    = 1'b1;
         dreq.dividend = acc_ff + 64'(div2 >> 1);
         dreq.divisor  = {1'b0, div2};
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a = mag2_ff;
      mul_b = mag2_ff;
      if (state_ff == S_MLO) begin
         mul_a = fbar_ff[31:0];
         mul_b = {7'b0, dmag_ff};
      end else if (state_ff == S_MHI) begin
         mul_a = fbar_ff[63:32];
         mul_b = {7'b0, dmag_ff};
      end
   end

   // next quotient/remainder step
   always_comb begin
      q_in = q_ff + qa_ff;
      r_in = r_ff + {1'b0, ra_ff};
      if (r_in >= {1'b0, den_ff}) begin
         r_in = r_in - {1'b0, den_ff};
         q_in = q_in + 33'd1;
      end
   end

   assign xsum  = neg_ff ? (35'(base_ff) - 35'(q_ff)) : (35'(base_ff) + 35'(q_ff));
   assign sq    = 39'((p_ff + 64'd8388608) >> 24);
   assign fsum  = 44'sd16777216 + 44'(x3_ff) * 44'sd2 + 44'(sq) * 44'sd3;
   assign total = 96'(lo_ff) + {p_ff, 32'b0};

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = (req_segment_count == 13'd0) ? S_ZERO : S_DIV1;
         S_DIV1:  state_in = S_WAIT1;
         S_WAIT1: if (drsp.done) state_in = S_RUN;
         S_RUN:   if (k_ff == den_ff) state_in = S_FLUSH;
         S_FLUSH: if (fl_ff == 3'd3) state_in = S_DIV2;
         S_DIV2:  state_in = S_WAIT2;
         S_WAIT2: if (drsp.done) state_in = S_MLO;
         S_MLO:   state_in = S_MHI;
         S_MHI:   state_in = S_SUM;
         S_SUM:   state_in = S_DONE;
         S_DONE:  if (out_free) state_in = S_IDLE;
         S_ZERO:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rule_ff      <= RULE_TRAP;
         rsp_valid_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_wdata != RULE_BAD) rule_ff <= csr_wdata;
         if ((state_ff == S_DONE || state_ff == S_ZERO) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         v1_ff <= (state_ff == S_RUN);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end

      // job capture
      if (accept) begin
         base_ff  <= 33'(req_start_x) <<< 8;
         neg_ff   <= dsig < 0;
         dmag_ff  <= (dsig < 0) ? 25'(-dsig) : 25'(dsig);
         n_ff     <= n_clip;
         den_ff   <= 16'(n_clip) * 16'd12;
         jrule_ff <= rule_ff;
      end

      // step constants after first division
      if (state_ff == S_WAIT1 && drsp.done) begin
         qa_ff  <= drsp.quotient[32:0];
         ra_ff  <= drsp.remainder[15:0];
         q_ff   <= '0;
         r_ff   <= {1'b0, den_ff >> 1};
         k_ff   <= '0;
         m_ff   <= '0;
         acc_ff <= '0;
      end

      // sample issue
      if (state_ff == S_RUN) begin
         x1_ff <= 33'(xsum);
         w1_ff <= ncq_weight(jrule_ff, m_ff, k_ff == 16'd0, k_ff == den_ff);
         q_ff  <= q_in;
         r_ff  <= r_in;
         k_ff  <= k_ff + 16'd1;
         m_ff  <= (m_ff == 4'd11) ? 4'd0 : m_ff + 4'd1;
         fl_ff <= '0;
      end
      if (state_ff == S_FLUSH) fl_ff <= fl_ff + 3'd1;

      // pipeline stages
      mag2_ff <= x1_ff[32] ? 32'(-x1_ff) : x1_ff[31:0];
      x2_ff   <= x1_ff;
      w2_ff   <= w1_ff;
      p_ff    <= 64'(mul_a) * 64'(mul_b);
      x3_ff   <= x2_ff;
      w3_ff   <= w2_ff;
      f4_ff   <= fsum[40:0];
      w4_ff   <= w3_ff;
      if (v4_ff) acc_ff <= acc_ff + 64'(47'(w4_ff) * 47'(f4_ff));

      // final scaling
      if (state_ff == S_WAIT2 && drsp.done) fbar_ff <= drsp.quotient;
      if (state_ff == S_MHI) lo_ff <= p_ff;
      if (state_ff == S_SUM) amag_ff <= 80'((total + 96'd32768) >> 16);

      // output register
      if (state_ff == S_DONE && out_free) begin
         err_ff <= 1'b0;
         if (!neg_ff && amag_ff > 80'h7FFF_FFFF_FFFF_FFFF) begin
            area_ff <= 64'h7FFF_FFFF_FFFF_FFFF;
            sat_ff  <= 1'b1;
         end else if (neg_ff && amag_ff > 80'h8000_0000_0000_0000) begin
            area_ff <= 64'h8000_0000_0000_0000;
            sat_ff  <= 1'b1;
         end else begin
            area_ff <= neg_ff ? (64'd0 - amag_ff[63:0]) : amag_ff[63:0];
            sat_ff  <= 1'b0;
         end
      end else if (state_ff == S_ZERO && out_free) begin
         area_ff <= '0;
         err_ff  <= 1'b1;
         sat_ff  <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_area      = area_ff;
   assign rsp_error     = err_ff;
   assign rsp_saturated = sat_ff;

   // checks
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_area == 64'd0 && !rsp_saturated)
      else $error("error item with nonzero area");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("not busy after accept");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      drsp.done |-> state_ff == S_WAIT1 || state_ff == S_WAIT2)
      else $error("divider done outside wait");

endmodule
